FILE: hw/rtl/vec4_fixed_point_alu_assert.svh
// ----------------------------------------------------------------------------
// vec4_fixed_point_alu_assert.svh
// Assertion macros used by the checker file vfa_check.sv.
// ----------------------------------------------------------------------------
`ifndef VEC4_FIXED_POINT_ALU_ASSERT_SVH
`define VEC4_FIXED_POINT_ALU_ASSERT_SVH

// clocked on clk, quiet while arst_n is low
`define VFA_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// clocked on clk, also checked during reset
`define VFA_ASSERT_RST(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/vfa_pkg.sv
// ----------------------------------------------------------------------------
// vfa_pkg
// Widths, stage counts, types and helpers of the vector fixed point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package vfa_pkg;

	localparam int DW     = 32;
	localparam int FRAC   = 16;
	localparam int NLANE  = 4;
	localparam int CMD_W  = 4;

	localparam int PROD_W = 2 * DW;
	localparam int SUM_W  = 2 * DW + 3;
	localparam int RAD_W  = 2 * DW + 2;
	localparam int ROOT_W = DW + 1;
	localparam int REM_W  = ROOT_W + 3;
	localparam int NUM_W  = DW + FRAC;
	localparam int DVS_W  = ROOT_W;

	// stage where the root is ready, stage where the quotient is ready
	localparam int SQ_S   = 3 + ROOT_W;
	localparam int QS     = SQ_S + NUM_W;

	localparam int IN_W   = CMD_W + 9 * DW;
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W  = 5 * DW + 1;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 4'd0,
		CMD_SUB   = 4'd1,
		CMD_MUL   = 4'd2,
		CMD_DIV   = 4'd3,
		CMD_SCALE = 4'd4,
		CMD_DIVS  = 4'd5,
		CMD_DOT   = 4'd6,
		CMD_LEN   = 4'd7,
		CMD_LENSQ = 4'd8,
		CMD_NORM  = 4'd9
	} cmd_t;

	typedef logic [DW-1:0] word_t;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic              neg;
	} prod_t;

	typedef struct packed {
		word_t alt;
		logic  qneg;
		logic  dsz;
		logic  ddz;
		word_t dvd;
		word_t dvs;
	} lane_t;

	typedef struct packed {
		word_t alt;
		logic  qneg;
		logic  dsz;
		logic  ddz;
	} side_t;

	function automatic word_t mag_of(input word_t v);
		return v[DW-1] ? word_t'(-v) : v;
	endfunction

	function automatic word_t sat_mag(input logic neg, input logic [SUM_W-1:0] m);
		logic [SUM_W-1:0] cap;
		word_t            x;
		cap = neg ? (SUM_W'(1) << (DW - 1)) : ((SUM_W'(1) << (DW - 1)) - SUM_W'(1));
		x = (m > cap) ? cap[DW-1:0] : m[DW-1:0];
		return neg ? word_t'(-x) : x;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vfa_lane.sv
// ----------------------------------------------------------------------------
// vfa_lane
// One component lane: operand magnitudes, product, add/sub, divide operands.
// ----------------------------------------------------------------------------
`default_nettype none

module vfa_lane (
	input  logic           clk,
	input  logic           en,
	input  vfa_pkg::cmd_t  cmd,
	input  vfa_pkg::cmd_t  cmd_s1,
	input  vfa_pkg::word_t a,
	input  vfa_pkg::word_t b,
	input  vfa_pkg::word_t s,
	output vfa_pkg::prod_t prod_s1,
	output vfa_pkg::lane_t info_s2
);
	import vfa_pkg::*;

	word_t       a_mag, b_mag, s_mag, m_op, as_sat, dvs_c, mres, alt_c;
	logic        m_neg, q_neg;
	logic [DW:0] sum_c;
	word_t       as_s1, araw_s1, dvd_s1, dvs_s1;
	logic        qneg_s1;

	always_comb begin
		a_mag = mag_of(a);
		b_mag = mag_of(b);
		s_mag = mag_of(s);
		m_op  = a_mag;
		m_neg = 1'b0;
		unique case (cmd)
			CMD_MUL, CMD_DOT: begin
				m_op  = b_mag;
				m_neg = a[DW-1] ^ b[DW-1];
			end
			CMD_SCALE: begin
				m_op  = s_mag;
				m_neg = a[DW-1] ^ s[DW-1];
			end
			default: ;
		endcase
		if (cmd == CMD_SUB) begin
			sum_c = {a[DW-1], a} - {b[DW-1], b};
		end else begin
			sum_c = {a[DW-1], a} + {b[DW-1], b};
		end
		as_sat = (sum_c[DW] != sum_c[DW-1]) ? {sum_c[DW], {(DW-1){~sum_c[DW]}}}
			: sum_c[DW-1:0];
		dvs_c = (cmd == CMD_DIV) ? b_mag : s_mag;
		q_neg = a[DW-1] ^ ((cmd == CMD_DIV) ? b[DW-1] : (cmd == CMD_DIVS) ? s[DW-1] : 1'b0);
	end

	always_comb begin
		mres = sat_mag(prod_s1.neg, SUM_W'(prod_s1.prod >> FRAC));
		unique case (cmd_s1)
			CMD_MUL, CMD_SCALE: alt_c = mres;
			CMD_NORM:           alt_c = araw_s1;
			default:            alt_c = as_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.prod <= PROD_W'(a_mag) * PROD_W'(m_op);
			prod_s1.neg  <= m_neg;
			as_s1        <= as_sat;
			araw_s1      <= a;
			dvd_s1       <= a_mag;
			dvs_s1       <= dvs_c;
			qneg_s1      <= q_neg;
			info_s2.alt  <= alt_c;
			info_s2.qneg <= qneg_s1;
			info_s2.dsz  <= (dvs_s1 == '0);
			info_s2.ddz  <= (dvd_s1 == '0);
			info_s2.dvd  <= dvd_s1;
			info_s2.dvs  <= dvs_s1;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/vfa_merge.sv
// ----------------------------------------------------------------------------
// vfa_merge
// Sums the lane products, then a pipelined square root, one root bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vfa_merge (
	input  logic                         clk,
	input  logic                         en,
	input  vfa_pkg::prod_t               prod_s1 [vfa_pkg::NLANE],
	output logic [vfa_pkg::ROOT_W-1:0]   root,
	output vfa_pkg::word_t               scal,
	output logic                         zero
);
	import vfa_pkg::*;

	logic signed [PROD_W:0]   sp [NLANE];
	logic [PROD_W+1:0]        pair_s2 [2];
	logic [SUM_W-1:0]         tot_s3;
	logic                     tneg;
	logic [SUM_W-1:0]         tmag;
	word_t                    scal_q [ROOT_W];
	logic                     zero_q [ROOT_W];
	logic [REM_W-1:0]         rem_q  [ROOT_W];
	logic [ROOT_W-1:0]        root_q [ROOT_W];
	logic [RAD_W-1:0]         rad_q  [ROOT_W];

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			sp[i] = prod_s1[i].neg ? -$signed({1'b0, prod_s1[i].prod})
				: $signed({1'b0, prod_s1[i].prod});
		end
		tneg = tot_s3[SUM_W-1];
		tmag = tneg ? SUM_W'(-tot_s3) : tot_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s2[0] <= {sp[0][PROD_W], sp[0]} + {sp[1][PROD_W], sp[1]};
			pair_s2[1] <= {sp[2][PROD_W], sp[2]} + {sp[3][PROD_W], sp[3]};
			tot_s3     <= {pair_s2[0][PROD_W+1], pair_s2[0]}
				+ {pair_s2[1][PROD_W+1], pair_s2[1]};
			scal_q[0]  <= sat_mag(tneg, tmag >> FRAC);
			zero_q[0]  <= (tot_s3 == '0);
			for (int k = 1; k < ROOT_W; k++) begin
				scal_q[k] <= scal_q[k-1];
				zero_q[k] <= zero_q[k-1];
			end
		end
	end

	for (genvar j = 0; j < ROOT_W; j++) begin : g_sq
		logic [REM_W-1:0]  rem_in, rem2, trial;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rad_in;
		logic              ge;

		if (j == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = tot_s3[RAD_W-1:0];
		end else begin : g_next
			assign rem_in  = rem_q[j-1];
			assign root_in = root_q[j-1];
			assign rad_in  = rad_q[j-1];
		end

		always_comb begin
			rem2  = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
			trial = REM_W'({root_in, 2'b01});
			ge    = (rem2 >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j]  <= ge ? (rem2 - trial) : rem2;
				root_q[j] <= {root_in[ROOT_W-2:0], ge};
				rad_q[j]  <= rad_in << 2;
			end
		end
	end

	assign root = root_q[ROOT_W-1];
	assign scal = scal_q[ROOT_W-1];
	assign zero = zero_q[ROOT_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/vfa_div.sv
// ----------------------------------------------------------------------------
// vfa_div
// Pipelined restoring divider, one quotient bit a stage, dividend scaled up.
// ----------------------------------------------------------------------------
`default_nettype none

module vfa_div (
	input  logic                        clk,
	input  logic                        en,
	input  vfa_pkg::word_t              dvd,
	input  logic [vfa_pkg::DVS_W-1:0]   dvs,
	output logic [vfa_pkg::NUM_W-1:0]   quo
);
	import vfa_pkg::*;

	logic [DVS_W-1:0] rem_q [NUM_W];
	logic [NUM_W-1:0] num_q [NUM_W];
	logic [NUM_W-1:0] quo_q [NUM_W];
	logic [DVS_W-1:0] d_q   [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_st
		logic [DVS_W-1:0] rem_in, d_in;
		logic [NUM_W-1:0] num_in, quo_in;
		logic [DVS_W:0]   rem2, diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = {dvd, {FRAC{1'b0}}};
			assign quo_in = '0;
			assign d_in   = dvs;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign num_in = num_q[k-1];
			assign quo_in = quo_q[k-1];
			assign d_in   = d_q[k-1];
		end

		always_comb begin
			rem2 = {rem_in, num_in[NUM_W-1]};
			ge   = (rem2 >= {1'b0, d_in});
			diff = rem2 - {1'b0, d_in};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? diff[DVS_W-1:0] : rem2[DVS_W-1:0];
				num_q[k] <= num_in << 1;
				quo_q[k] <= {quo_in[NUM_W-2:0], ge};
				d_q[k]   <= d_in;
			end
		end
	end

	assign quo = quo_q[NUM_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/vec4_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// vec4_fixed_point_alu
// Four component Q16.16 vector ALU: four lanes, product merge with square
// root, per-lane dividers, saturated results.
// ----------------------------------------------------------------------------
// channel  dir  signals                   contents
// s_       in   tvalid tready tdata[295:0] cmd, a xyzw, b xyzw, scalar_in
// m_       out  tvalid tready tdata[167:0] r xyzw, scalar_out, div_zero
//
// One item per cycle while the output is not stalled; stages: sum, 33 root
// stages, 48 divide stages, output register.
// The whole pipeline advances when the output register is empty or taken;
// a stalled output freezes every stage and deasserts s_tready.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module vec4_fixed_point_alu (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// cmd[3:0], a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in, zero pad
	input  logic [vfa_pkg::IN_TW-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// r_x, r_y, r_z, r_w, scalar_out, div_zero, zero pad
	output logic [vfa_pkg::OUT_TW-1:0]  m_tdata
);
	import vfa_pkg::*;

	logic              en;
	cmd_t              cmd_in;
	word_t             a_in [NLANE];
	word_t             b_in [NLANE];
	word_t             s_in;
	logic              vld_q [QS];
	cmd_t              cmd_q [QS];
	prod_t             prod_s1 [NLANE];
	lane_t             info_s2 [NLANE];
	lane_t             l1_q [SQ_S-2][NLANE];
	logic [ROOT_W-1:0] root;
	word_t             scal;
	logic              zero;
	word_t             scal_sel;
	logic [DVS_W-1:0]  dvs_sel [NLANE];
	logic [NUM_W-1:0]  quo [NLANE];
	side_t             side_q [NUM_W][NLANE];
	word_t             scal2_q [NUM_W];
	logic              zero2_q [NUM_W];
	word_t             r_c [NLANE];
	word_t             sc_c;
	logic              dz_c;
	side_t             sd;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_comb begin
		cmd_in = cmd_t'(s_tdata[CMD_W-1:0]);
		for (int i = 0; i < NLANE; i++) begin
			a_in[i] = s_tdata[CMD_W + DW * i +: DW];
			b_in[i] = s_tdata[CMD_W + DW * (NLANE + i) +: DW];
		end
		s_in = s_tdata[CMD_W + DW * 2 * NLANE +: DW];
	end

	for (genvar i = 0; i < NLANE; i++) begin : g_lane
		vfa_lane u_lane (
			.clk     (clk),
			.en      (en),
			.cmd     (cmd_in),
			.cmd_s1  (cmd_q[0]),
			.a       (a_in[i]),
			.b       (b_in[i]),
			.s       (s_in),
			.prod_s1 (prod_s1[i]),
			.info_s2 (info_s2[i])
		);

		vfa_div u_div (
			.clk (clk),
			.en  (en),
			.dvd (l1_q[SQ_S-3][i].dvd),
			.dvs (dvs_sel[i]),
			.quo (quo[i])
		);
	end

	vfa_merge u_merge (
		.clk     (clk),
		.en      (en),
		.prod_s1 (prod_s1),
		.root    (root),
		.scal    (scal),
		.zero    (zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QS; k++) begin
				vld_q[k] <= 1'b0;
			end
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_q[0] <= s_tvalid;
			for (int k = 1; k < QS; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
			m_tvalid <= vld_q[QS-1];
		end
	end

	always_comb begin
		scal_sel = (cmd_q[SQ_S-1] == CMD_LEN) ? sat_mag(1'b0, SUM_W'(root)) : scal;
		for (int i = 0; i < NLANE; i++) begin
			dvs_sel[i] = (cmd_q[SQ_S-1] == CMD_NORM) ? root
				: DVS_W'(l1_q[SQ_S-3][i].dvs);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_q[0] <= cmd_in;
			for (int k = 1; k < QS; k++) begin
				cmd_q[k] <= cmd_q[k-1];
			end
			l1_q[0] <= info_s2;
			for (int k = 1; k < SQ_S - 2; k++) begin
				l1_q[k] <= l1_q[k-1];
			end
			for (int i = 0; i < NLANE; i++) begin
				side_q[0][i].alt  <= l1_q[SQ_S-3][i].alt;
				side_q[0][i].qneg <= l1_q[SQ_S-3][i].qneg;
				side_q[0][i].dsz  <= l1_q[SQ_S-3][i].dsz;
				side_q[0][i].ddz  <= l1_q[SQ_S-3][i].ddz;
			end
			scal2_q[0] <= scal_sel;
			zero2_q[0] <= zero;
			for (int k = 1; k < NUM_W; k++) begin
				side_q[k]  <= side_q[k-1];
				scal2_q[k] <= scal2_q[k-1];
				zero2_q[k] <= zero2_q[k-1];
			end
		end
	end

	always_comb begin
		sc_c = '0;
		dz_c = 1'b0;
		sd   = '0;
		for (int i = 0; i < NLANE; i++) begin
			r_c[i] = '0;
			sd     = side_q[NUM_W-1][i];
			unique case (cmd_q[QS-1])
				CMD_ADD, CMD_SUB, CMD_MUL, CMD_SCALE: r_c[i] = sd.alt;
				CMD_DIV, CMD_DIVS: begin
					if (sd.dsz) begin
						dz_c   = 1'b1;
						r_c[i] = sd.ddz ? '0 : sat_mag(sd.qneg, '1);
					end else begin
						r_c[i] = sat_mag(sd.qneg, SUM_W'(quo[i]));
					end
				end
				CMD_NORM: begin
					r_c[i] = zero2_q[NUM_W-1] ? sd.alt : sat_mag(sd.qneg, SUM_W'(quo[i]));
				end
				default: ;
			endcase
		end
		if (cmd_q[QS-1] == CMD_DOT || cmd_q[QS-1] == CMD_LEN
				|| cmd_q[QS-1] == CMD_LENSQ) begin
			sc_c = scal2_q[NUM_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= OUT_TW'({dz_c, sc_c, r_c[3], r_c[2], r_c[1], r_c[0]});
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/vfa_check.sv
// ----------------------------------------------------------------------------
// vfa_check
// Port-level checks of the vector ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vec4_fixed_point_alu_assert.svh"

module vfa_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [vfa_pkg::OUT_TW-1:0]  m_tdata
);
	import vfa_pkg::*;

	`VFA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`VFA_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled result changed")
	`VFA_ASSERT(a_ready_empty, !m_tvalid |-> s_tready, "input blocked with empty output")
	`VFA_ASSERT(a_dz_scalar, m_tvalid && m_tdata[5*DW] |-> m_tdata[5*DW-1:4*DW] == '0, "div_zero with scalar result")
	`VFA_ASSERT_RST(a_reset_idle, !arst_n |=> !m_tvalid, "output valid during reset")

endmodule

bind vec4_fixed_point_alu vfa_check u_vfa_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/sv/vec4_alu_checker.sv
// ----------------------------------------------------------------------------
// vec4_alu_checker
// Watches both streams of the vector ALU, computes the expected result of
// every accepted item and compares it field by field with the output items.
// ----------------------------------------------------------------------------
module vec4_alu_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [vfa_pkg::IN_TW-1:0]  s_tdata,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [vfa_pkg::OUT_TW-1:0] m_tdata,
	output int                         errors,
	output int                         pending,
	output int                         results_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import vfa_pkg::*;

	typedef struct {
		logic [31:0] r [4];
		logic [31:0] s;
		logic        dz;
	} alu_result_t;

	localparam logic [31:0] MAXP = 32'h7fffffff;
	localparam logic [31:0] MAXN = 32'h80000000;

	alu_result_t result_queue[$];

	function automatic logic [31:0] clamp(input logic signed [130:0] v);
		if (v > $signed({99'd0, MAXP})) return MAXP;
		if (v < -$signed({99'd0, MAXN})) return MAXN;
		return v[31:0];
	endfunction

	// signed division truncating toward zero on a wide value
	function automatic logic signed [130:0] tdiv(input logic signed [130:0] n,
			input logic signed [130:0] d);
		logic [130:0] mn, md, q;
		logic         ng;
		ng = (n < 0) != (d < 0);
		mn = (n < 0) ? -n : n;
		md = (d < 0) ? -d : d;
		q = mn / md;
		return ng ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic [31:0] qdiv(input logic signed [31:0] a,
			input logic signed [130:0] d, inout logic dz);
		if (d == 0) begin
			dz = 1'b1;
			return (a > 0) ? MAXP : (a < 0) ? MAXN : 32'd0;
		end
		return clamp(tdiv($signed(131'(a)) <<< 16, d));
	endfunction

	function automatic logic [130:0] root(input logic [130:0] s);
		logic [130:0] res, c;
		res = 0;
		for (int i = 65; i >= 0; i--) begin
			c = res | (131'd1 << i);
			if (c * c <= s) res = c;
		end
		return res;
	endfunction

	function automatic alu_result_t compute_alu(input logic [IN_TW-1:0] d);
		alu_result_t        e;
		logic [3:0]         op;
		logic signed [31:0] a [4], b [4], sc;
		logic signed [130:0] acc, sq;
		logic               dz;
		op = d[3:0];
		for (int i = 0; i < 4; i++) begin
			a[i] = d[4 + 32*i +: 32];
			b[i] = d[132 + 32*i +: 32];
			e.r[i] = 0;
		end
		sc = d[260 +: 32];
		e.s = 0;
		dz = 0;
		acc = 0;
		sq = 0;
		for (int i = 0; i < 4; i++) begin
			acc += $signed(131'(a[i])) * $signed(131'(b[i]));
			sq += $signed(131'(a[i])) * $signed(131'(a[i]));
		end
		case (op)
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_SCALE, CMD_DIVS:
				for (int i = 0; i < 4; i++)
					case (op)
						CMD_ADD: e.r[i] = clamp($signed(131'(a[i])) + b[i]);
						CMD_SUB: e.r[i] = clamp($signed(131'(a[i])) - b[i]);
						CMD_MUL: e.r[i] = clamp(tdiv($signed(131'(a[i])) * b[i], 131'sd65536));
						CMD_DIV: e.r[i] = qdiv(a[i], $signed(131'(b[i])), dz);
						CMD_SCALE: e.r[i] = clamp(tdiv($signed(131'(a[i])) * sc, 131'sd65536));
						default: e.r[i] = qdiv(a[i], $signed(131'(sc)), dz);
					endcase
			CMD_DOT: e.s = clamp(tdiv(acc, 131'sd65536));
			CMD_LEN: e.s = clamp($signed(root(sq)));
			CMD_LENSQ: e.s = clamp(sq >>> 16);
			CMD_NORM: begin
				if (sq == 0) begin
					for (int i = 0; i < 4; i++) e.r[i] = a[i];
				end else begin
					for (int i = 0; i < 4; i++) e.r[i] = qdiv(a[i], $signed(root(sq)), dz);
					dz = 0;
				end
			end
			default: ;
		endcase
		e.dz = dz;
		return e;
	endfunction

	initial begin
		errors = 0;
		results_seen = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		alu_result_t e;
		if (arst_n && s_tvalid && s_tready) result_queue.push_back(compute_alu(s_tdata));
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (result_queue.size() == 0) begin
				$error("output item with no expected result");
				errors++;
			end else begin
				e = result_queue.pop_front();
				for (int i = 0; i < 4; i++)
					if (m_tdata[32*i +: 32] !== e.r[i]) begin
						$error("r[%0d]: expected %h, actual %h", i, e.r[i], m_tdata[32*i +: 32]);
						errors++;
					end
				if (m_tdata[128 +: 32] !== e.s) begin
					$error("scalar_out: expected %h, actual %h", e.s, m_tdata[128 +: 32]);
					errors++;
				end
				if (m_tdata[160] !== e.dz) begin
					$error("div_zero: expected %b, actual %b", e.dz, m_tdata[160]);
					errors++;
				end
			end
		end
		pending = result_queue.size();
	end
endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives directed and random vector commands with bursty input and a
// stalling output into the vector ALU; the checker gives the verdict data.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vfa_pkg::*;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              s_tvalid = 0;
	logic              s_tready;
	logic [IN_TW-1:0]  s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 0;
	logic [OUT_TW-1:0] m_tdata;
	int                errors, pending, results_seen;
	int                sent = 0;

	always #10 clk = ~clk;

	vec4_fixed_point_alu dut (.*);

	vec4_alu_checker chk (.*);

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'd0;
			3: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
			4: return 32'($signed($urandom_range(0, 131072)) - 65536);
			5: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic [3:0] op, input logic [31:0] w [9]);
		logic [IN_TW-1:0] d;
		d = '0;
		d[3:0] = op;
		for (int i = 0; i < 9; i++) d[4 + 32*i +: 32] = w[i];
		s_tdata <= d;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_random(input logic [3:0] op);
		logic [31:0] w [9];
		for (int i = 0; i < 9; i++) w[i] = pick_word();
		send_item(op, w);
	endtask

	// receiver stall pattern
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(1, 60)) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= $urandom_range(0, 1);
					default: m_tready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [31:0] w [9];
		int          burst;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: extremes, every command, zero divisors, zero vector
		for (int op = 0; op < 10; op++) begin
			for (int i = 0; i < 9; i++) w[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
			send_item(4'(op), w);
		end
		for (int i = 0; i < 9; i++) w[i] = 0;
		w[0] = 32'h00030000;
		w[1] = 32'hfffd0000;
		send_item(CMD_DIV, w);
		send_item(CMD_DIVS, w);
		for (int i = 0; i < 9; i++) w[i] = 0;
		send_item(CMD_NORM, w);
		send_item(CMD_DIV, w);
		send_item(CMD_LEN, w);
		for (int i = 0; i < 9; i++) w[i] = 32'hffffffff;
		send_item(CMD_NORM, w);
		send_item(CMD_MUL, w);
		send_item(4'd15, w);
		send_item(4'd10, w);
		w[0] = 32'h00010000;
		send_item(CMD_NORM, w);
		s_tvalid <= 1'b0;
		// random in bursts
		while (sent < 1550) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
			repeat (burst)
				if (sent < 1550)
					send_random(($urandom_range(0, 15) == 0) ?
						4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9)));
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
		end
		while (pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);
		$display("Sent %0d items over all ten commands and unknown codes; %0d results checked.",
			sent, results_seen);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

FILE: vec4_fixed_point_alu.f
+incdir+hw/rtl
hw/rtl/vfa_pkg.sv
hw/rtl/vfa_lane.sv
hw/rtl/vfa_merge.sv
hw/rtl/vfa_div.sv
hw/rtl/vec4_fixed_point_alu.sv
hw/rtl/vfa_check.sv
tb/sv/vec4_alu_checker.sv
tb/sv/tb.sv
